@@ src/cdll_pkg.sv @@
// cdll_pkg: types and constants shared by the cursor list controller, datapath and top level
// no dependencies

package cdll_pkg;

	localparam int OPCODE_W = 4;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int WIDE_W   = 64;

	typedef enum logic [OPCODE_W-1:0] {
		OP_STATUS    = 4'd0,
		OP_HEAD      = 4'd1,
		OP_TAIL      = 4'd2,
		OP_NEXT      = 4'd3,
		OP_PREV      = 4'd4,
		OP_READ      = 4'd5,
		OP_MODIFY    = 4'd6,
		OP_REMOVE    = 4'd7,
		OP_INS_RIGHT = 4'd8,
		OP_INS_LEFT  = 4'd9
	} op_t;

	// what the datapath does in its execute cycle
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_HEAD,
		ACT_TAIL,
		ACT_NEXT,
		ACT_PREV,
		ACT_MODIFY,
		ACT_REMOVE,
		ACT_INS_R,
		ACT_INS_L
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD,
		ST_LINK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [OPCODE_W-1:0]      opcode;
		logic signed [DATA_W-1:0] data_value;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic                     list_empty;
		logic                     off_list;
		logic                     refused;
		logic [COUNT_W-1:0]       element_count;
	} result_t;

	typedef struct packed {
		logic accept;
		logic exec;
		act_t act;
		logic refused;
		logic load;
		logic link;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic                empty;
		logic                off;
		logic                full;
		logic                out_free;
	} dp_status_t;

endpackage

@@ src/cdll_ctrl.sv @@
// cdll_ctrl: sequencing state machine of the cursor list, decodes the opcode into datapath actions
// depends on cdll_pkg

module cdll_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  cdll_pkg::dp_status_t status,
	output cdll_pkg::dp_cmd_t    cmd
);
	import cdll_pkg::*;

	state_t state_q, state_d;
	act_t   act;
	logic   refuse;
	logic   needs_load;
	logic   needs_link;

	// opcode decode against the list state seen at execute
	always_comb begin
		act    = ACT_NONE;
		refuse = 1'b0;
		case (status.opcode)
			OP_HEAD: begin
				if (status.empty) refuse = 1'b1;
				else act = ACT_HEAD;
			end
			OP_TAIL: begin
				if (status.empty) refuse = 1'b1;
				else act = ACT_TAIL;
			end
			OP_NEXT: begin
				if (status.off) refuse = 1'b1;
				else act = ACT_NEXT;
			end
			OP_PREV: begin
				if (status.off) refuse = 1'b1;
				else act = ACT_PREV;
			end
			OP_READ: begin
				refuse = status.off;
			end
			OP_MODIFY: begin
				if (status.off) refuse = 1'b1;
				else act = ACT_MODIFY;
			end
			OP_REMOVE: begin
				if (status.off) refuse = 1'b1;
				else act = ACT_REMOVE;
			end
			OP_INS_RIGHT: begin
				if ((status.off && !status.empty) || status.full) refuse = 1'b1;
				else act = ACT_INS_R;
			end
			OP_INS_LEFT: begin
				if ((status.off && !status.empty) || status.full) refuse = 1'b1;
				else act = ACT_INS_L;
			end
			default: begin
				act    = ACT_NONE;
				refuse = 1'b0;
			end
		endcase
	end

	assign needs_load = act inside {ACT_HEAD, ACT_TAIL, ACT_NEXT, ACT_PREV, ACT_REMOVE};
	assign needs_link = act inside {ACT_INS_R, ACT_INS_L};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (needs_load) state_d = ST_LOAD;
				else if (needs_link) state_d = ST_LINK;
				else if (status.out_free) state_d = ST_IDLE;
				else state_d = ST_RESP;
			end
			ST_LOAD, ST_LINK, ST_RESP: begin
				if (status.out_free) state_d = ST_IDLE;
				else state_d = ST_RESP;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall   = 1'b1;
		cmd          = '0;
		cmd.act      = ACT_NONE;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				cmd.accept = item_valid;
			end
			ST_EXEC: begin
				cmd.exec     = 1'b1;
				cmd.act      = act;
				cmd.refused  = refuse;
				cmd.out_load = !needs_load && !needs_link && status.out_free;
			end
			ST_LOAD: begin
				cmd.load     = 1'b1;
				cmd.out_load = status.out_free;
			end
			ST_LINK: begin
				cmd.link     = 1'b1;
				cmd.out_load = status.out_free;
			end
			ST_RESP: begin
				cmd.out_load = status.out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/cdll_dp.sv @@
// cdll_dp: link, value and free-slot memories, cursor and count registers, result register
// depends on cdll_pkg; driven by cdll_ctrl

module cdll_dp #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cdll_pkg::item_t      item,
	output cdll_pkg::result_t    result,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  cdll_pkg::dp_cmd_t    cmd,
	output cdll_pkg::dp_status_t status
);
	import cdll_pkg::*;

	localparam int SW = $clog2(CAPACITY + 1);
	localparam int FW = $clog2(CAPACITY);

	// slot 0 is the sentinel; its links live in head_q and tail_q
	logic [SW-1:0]         next_mem [1:CAPACITY];
	logic [SW-1:0]         prev_mem [1:CAPACITY];
	logic [VALUE_BITS-1:0] val_mem  [1:CAPACITY];
	logic [SW-1:0]         free_mem [0:CAPACITY-1];

	logic [OPCODE_W-1:0]   op_q;
	logic [VALUE_BITS-1:0] dv_q;
	logic [SW-1:0]         cursor_q, count_q, top_q, min_q, head_q, tail_q;
	logic [SW-1:0]         lnk_l_q, lnk_r_q;
	logic [VALUE_BITS-1:0] cur_val_q;
	logic                  refused_q;
	logic [SW-1:0]         nx_rd_q, pv_rd_q, fr_rd_q;
	logic [VALUE_BITS-1:0] val_rd_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic [SW-1:0]         cur_d, cnt_d, top_d, min_d, head_d, tail_d, lnk_l_d, lnk_r_d;
	logic [VALUE_BITS-1:0] val_d;
	logic                  ref_d;
	logic [SW-1:0]         nb_next, nb_prev, new_slot, top_m1, ins_left, ins_right;
	logic                  fresh;

	logic                  nx_we, pv_we, vm_we, fr_we;
	logic [SW-1:0]         nx_wa, nx_wd, pv_wa, pv_wd, vm_wa, fr_wd;
	logic [FW-1:0]         fr_wa;
	logic [VALUE_BITS-1:0] vm_wd;

	logic signed [WIDE_W-1:0]     dv_wide;
	logic signed [VALUE_BITS-1:0] val_s;
	logic signed [WIDE_W-1:0]     val_wide;
	logic                         out_free;

	assign dv_wide = WIDE_W'($signed(item.data_value));

	// neighbors of the cursor, sentinel links come from registers
	assign nb_next = (cursor_q == '0) ? head_q : nx_rd_q;
	assign nb_prev = (cursor_q == '0) ? tail_q : pv_rd_q;
	assign top_m1  = top_q - SW'(1);
	// stack entries below the low mark were never written; a fresh slot number is taken from the stack pointer
	assign fresh    = (top_q == min_q);
	assign new_slot = fresh ? top_q : fr_rd_q;
	assign ins_left  = (cmd.act == ACT_INS_L) ? nb_prev : cursor_q;
	assign ins_right = (cmd.act == ACT_INS_L) ? cursor_q : nb_next;

	always_comb begin
		cur_d   = cursor_q;
		cnt_d   = count_q;
		val_d   = cur_val_q;
		top_d   = top_q;
		min_d   = min_q;
		head_d  = head_q;
		tail_d  = tail_q;
		lnk_l_d = lnk_l_q;
		lnk_r_d = lnk_r_q;
		ref_d   = refused_q;
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
		vm_we = 1'b0; vm_wa = '0; vm_wd = '0;
		fr_we = 1'b0; fr_wa = '0; fr_wd = '0;
		if (cmd.exec) ref_d = cmd.refused;
		case (cmd.act)
			ACT_HEAD: cur_d = head_q;
			ACT_TAIL: cur_d = tail_q;
			ACT_NEXT: cur_d = nb_next;
			ACT_PREV: cur_d = nb_prev;
			ACT_MODIFY: begin
				val_d = dv_q;
				vm_we = 1'b1;
				vm_wa = cursor_q;
				vm_wd = dv_q;
			end
			ACT_REMOVE: begin
				cur_d = nb_prev;
				cnt_d = count_q - SW'(1);
				if (nb_prev == '0) begin
					head_d = nb_next;
				end else begin
					nx_we = 1'b1;
					nx_wa = nb_prev;
					nx_wd = nb_next;
				end
				if (nb_next == '0) begin
					tail_d = nb_prev;
				end else begin
					pv_we = 1'b1;
					pv_wa = nb_next;
					pv_wd = nb_prev;
				end
				fr_we = 1'b1;
				fr_wa = top_q[FW-1:0];
				fr_wd = cursor_q;
				top_d = top_q + SW'(1);
			end
			ACT_INS_R, ACT_INS_L: begin
				cur_d   = new_slot;
				cnt_d   = count_q + SW'(1);
				val_d   = dv_q;
				top_d   = top_m1;
				if (fresh) min_d = top_m1;
				vm_we   = 1'b1;
				vm_wa   = new_slot;
				vm_wd   = dv_q;
				nx_we   = 1'b1;
				nx_wa   = new_slot;
				nx_wd   = ins_right;
				pv_we   = 1'b1;
				pv_wa   = new_slot;
				pv_wd   = ins_left;
				lnk_l_d = ins_left;
				lnk_r_d = ins_right;
			end
			default: ;
		endcase
		// second link phase of an insert, the cursor already sits on the new slot
		if (cmd.link) begin
			if (lnk_l_q == '0) begin
				head_d = cursor_q;
			end else begin
				nx_we = 1'b1;
				nx_wa = lnk_l_q;
				nx_wd = cursor_q;
			end
			if (lnk_r_q == '0) begin
				tail_d = cursor_q;
			end else begin
				pv_we = 1'b1;
				pv_wa = lnk_r_q;
				pv_wd = cursor_q;
			end
		end
		if (cmd.load) val_d = val_rd_q;
	end

	// memories
	always_ff @(posedge clk) begin
		if (nx_we) next_mem[nx_wa] <= nx_wd;
		if (cmd.accept && cursor_q != '0) nx_rd_q <= next_mem[cursor_q];
	end

	always_ff @(posedge clk) begin
		if (pv_we) prev_mem[pv_wa] <= pv_wd;
		if (cmd.accept && cursor_q != '0) pv_rd_q <= prev_mem[cursor_q];
	end

	always_ff @(posedge clk) begin
		if (vm_we) val_mem[vm_wa] <= vm_wd;
		if (cmd.exec && cur_d != '0) val_rd_q <= val_mem[cur_d];
	end

	always_ff @(posedge clk) begin
		if (fr_we) free_mem[fr_wa] <= fr_wd;
		if (cmd.accept && top_q != '0) fr_rd_q <= free_mem[top_m1[FW-1:0]];
	end

	// item payload and insert link holding registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= item.opcode;
			dv_q <= VALUE_BITS'(dv_wide);
		end
		lnk_l_q   <= lnk_l_d;
		lnk_r_q   <= lnk_r_d;
		cur_val_q <= val_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			count_q   <= '0;
			top_q     <= SW'(CAPACITY);
			min_q     <= SW'(CAPACITY);
			head_q    <= '0;
			tail_q    <= '0;
			refused_q <= 1'b0;
		end else begin
			cursor_q  <= cur_d;
			count_q   <= cnt_d;
			top_q     <= top_d;
			min_q     <= min_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			refused_q <= ref_d;
		end
	end

	// result register
	assign val_s    = val_d;
	assign val_wide = WIDE_W'(val_s);
	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.read_value    <= (cur_d == '0) ? '0 : $signed(val_wide[DATA_W-1:0]);
			out_q.list_empty    <= (cnt_d == '0);
			out_q.off_list      <= (cur_d == '0);
			out_q.refused       <= ref_d;
			out_q.element_count <= COUNT_W'(cnt_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

	assign status.opcode   = op_q;
	assign status.empty    = (count_q == '0);
	assign status.off      = (cursor_q == '0);
	assign status.full     = (top_q == '0);
	assign status.out_free = out_free;

endmodule

@@ src/cursor_doubly_linked_list_top.sv @@
// Bounded circular doubly linked list with a sentinel slot and a cursor. One item is taken at
// a time and gives exactly one result. Head, tail, next, prev and remove pass through the load
// state, the registered read of the value memory at the new cursor; inserts pass through the
// link state, the second write phase that links the two neighbor slots in the single-write
// link memories. Status, read, modify and refused operations need neither state. A new item
// is taken the cycle after its predecessor's result is loaded into the output register,
// which holds it while the result side stalls. No clearing pass runs after reset: the
// sentinel links sit in registers and the free-slot stack uses a low mark.
// depends on cdll_pkg, cdll_ctrl, cdll_dp

module cursor_doubly_linked_list_top #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  cdll_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output cdll_pkg::result_t result
);
	import cdll_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	cdll_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	cdll_dp #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

endmodule
